// ----- sv/fqr_pkg.sv -----
// fqr_pkg: shared types, sizes and codes for the FIFO queue with remove by identifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fqr_pkg;
	localparam int QUEUE_DEPTH = 64;
	localparam int ID_WIDTH    = 6;
	localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] FUNC_PUSH   = 2'd0;
	localparam logic [1:0] FUNC_POP    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_NOMATCH = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]          func;
		logic [ID_WIDTH-1:0] id_in;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ID_WIDTH-1:0]  id_out;
		logic                 now_empty;
		logic [CNT_WIDTH-1:0] occupancy_out;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SH_RD,
		S_SH_WR
	} state_t;
endpackage
`default_nettype wire

// ----- sv/fifo_queue_with_remove_by_id.sv -----
// fifo_queue_with_remove_by_id: ordered identifier queue with push, pop and remove-first-match.
// Depends on fqr_pkg and fqr_ram.
`timescale 1ns / 1ps
`default_nettype none
//
// channel   | ports                 | handshake
// ----------+-----------------------+---------------------------------------
// request   | start, busy, req      | beat taken when start & !busy
// result    | done, rsp             | one-cycle strobe, cannot be stalled
//
// Steps: push and unused codes finish in the idle state; pop issues one RAM
// read in the idle state and takes the data in S_POP. Remove: the idle state
// takes the beat, then S_SCAN_RD and S_SCAN_CMP run per entry scanned from
// the head up to the match, then S_SH_RD and S_SH_WR per entry behind it to
// close the gap (read, write back), over the single RAM port pair.
// Reset clears count and head pointer; RAM contents need no clearing.
// The result is registered from the last step; busy drops in the cycle in which done rises.
module fifo_queue_with_remove_by_id (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire fqr_pkg::req_t req,
	output logic              busy,
	output logic              done,
	output fqr_pkg::rsp_t     rsp
);
	localparam int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH;
	localparam int ID_WIDTH    = fqr_pkg::ID_WIDTH;
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = fqr_pkg::CNT_WIDTH;

	// circular storage: logical slot 0 is at head_q
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	fqr_pkg::state_t state_q, state_d;
	logic [AW-1:0]       head_q, head_d;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       off_q, off_d;     // scan / shift position from head
	logic [ID_WIDTH-1:0] id_q, id_d;       // identifier being removed
	logic                done_q, done_d;
	fqr_pkg::rsp_t       rsp_q, rsp_d;

	logic                we, re;
	logic [AW-1:0]       waddr, raddr;
	logic [ID_WIDTH-1:0] wdata, rdata;
	logic [CW-1:0]       off_nx;

	fqr_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign off_nx = off_q + CW'(1);

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		off_d   = off_q;
		id_d    = id_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		rsp_d.status = fqr_pkg::STAT_OK;
		rsp_d.id_out = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;

		case (state_q)
			fqr_pkg::S_IDLE: begin
				if (start) begin
					id_d  = req.id_in;
					off_d = '0;
					case (req.func)
						fqr_pkg::FUNC_PUSH: begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								rsp_d.status = fqr_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = phys(head_q, count_q);
								wdata   = req.id_in;
								count_d = count_q + CW'(1);
							end
							done_d = 1'b1;
						end
						fqr_pkg::FUNC_POP: begin
							if (count_q == '0) begin
								rsp_d.status = fqr_pkg::STAT_EMPTY;
								done_d       = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_d = fqr_pkg::S_POP;
							end
						end
						fqr_pkg::FUNC_REMOVE: begin
							if (count_q == '0) begin
								rsp_d.status = fqr_pkg::STAT_NOMATCH;
								done_d       = 1'b1;
							end else begin
								state_d = fqr_pkg::S_SCAN_RD;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			fqr_pkg::S_POP: begin
				rsp_d.id_out = rdata;
				head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_d = count_q - CW'(1);
				done_d  = 1'b1;
				state_d = fqr_pkg::S_IDLE;
			end
			fqr_pkg::S_SCAN_RD: begin
				re      = 1'b1;
				raddr   = phys(head_q, off_q);
				state_d = fqr_pkg::S_SCAN_CMP;
			end
			fqr_pkg::S_SCAN_CMP: begin
				if (rdata == id_q) begin
					if (off_nx == count_q) begin
						// match is the last entry: nothing to shift
						count_d = count_q - CW'(1);
						done_d  = 1'b1;
						state_d = fqr_pkg::S_IDLE;
					end else begin
						state_d = fqr_pkg::S_SH_RD;
					end
				end else if (off_nx == count_q) begin
					rsp_d.status = fqr_pkg::STAT_NOMATCH;
					done_d       = 1'b1;
					state_d      = fqr_pkg::S_IDLE;
				end else begin
					off_d   = off_nx;
					state_d = fqr_pkg::S_SCAN_RD;
				end
			end
			fqr_pkg::S_SH_RD: begin
				re      = 1'b1;
				raddr   = phys(head_q, off_nx);
				state_d = fqr_pkg::S_SH_WR;
			end
			fqr_pkg::S_SH_WR: begin
				// move entry off+1 down to off
				we    = 1'b1;
				waddr = phys(head_q, off_q);
				wdata = rdata;
				off_d = off_nx;
				if (off_nx + CW'(1) == count_q) begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					state_d = fqr_pkg::S_IDLE;
				end else begin
					state_d = fqr_pkg::S_SH_RD;
				end
			end
			default: state_d = fqr_pkg::S_IDLE;
		endcase

		rsp_d.now_empty     = (count_d == '0);
		rsp_d.occupancy_out = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqr_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d;
		id_q  <= id_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != fqr_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
`default_nettype wire

// ----- sv/fqr_ram.sv -----
// fqr_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fqr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
